// ===== hw/rtl/tes_pkg.sv =====
`default_nettype none
package tes_pkg;

  // Default edge length in vertices
  localparam int EDGE_VERTICES_DEF = 17;
  // Vertex index width carried in structs, enough for the largest edge
  localparam int IDX_W = 6;

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 8;
  localparam logic [CFG_AW-1:0] CFG_FIX_ENABLE = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LEVEL_DIFF = 2'd1;

  // Task queue between front and back
  localparam int FIFO_DEPTH = 4;

  // Normaliser widths
  localparam int UNIT_SHIFT = 28;                  // Q1.14 squared
  localparam int SQ_W       = 31;                  // square of a 16-bit component
  localparam int LEN_W      = 32;                  // sum of three squares
  localparam int NUM_W      = SQ_W + UNIT_SHIFT;   // dividend width
  localparam int Q_W        = 30;                  // quotient never exceeds 2^28
  localparam int DIV_STEPS  = NUM_W;
  localparam int SQRT_STEPS = 15;
  localparam int CNT_W      = 6;

  typedef struct packed {
    logic signed [23:0] vertex_height;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } vtx_in_t;

  typedef struct packed {
    logic signed [23:0] fixed_height;
    logic signed [15:0] fixed_nx;
    logic signed [15:0] fixed_ny;
    logic signed [15:0] fixed_nz;
    logic               last_vertex;
  } vtx_out_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    vtx_in_t          data;
  } store_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] r;
    logic [2:0]       shift;
    logic             norm;
    logic             last;
  } task_t;

  typedef enum logic [1:0] {F_LOAD, F_ISSUE, F_WAIT} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_RD_LO, B_RD_HI, B_INTERP, B_SQ, B_DSTART, B_DIV, B_SQI, B_SQRT, B_DONE
  } back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tes_fifo.sv =====
`default_nettype none
module tes_fifo
  import tes_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire task_t push_data,
  output logic       full,
  input  wire logic  pop,
  output task_t      pop_data,
  output logic       empty
);
  localparam int PW = $clog2(FIFO_DEPTH);

  task_t             slots [FIFO_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;

  assign full     = (count == (PW+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tes_front.sv =====
`default_nettype none
module tes_front
  import tes_pkg::*;
#(
  parameter int EDGE_VERTICES = EDGE_VERTICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire vtx_in_t           in_data,
  input  wire logic              cfg_valid,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  output store_wr_t              wr,
  output logic                   push,
  output task_t                  push_data,
  input  wire logic              fifo_full,
  input  wire logic              drained
);
  localparam int AW    = $clog2(EDGE_VERTICES);
  localparam int D_MAX = $clog2(EDGE_VERTICES) - 1;
  localparam logic [IDX_W:0] LAST_IDX = (IDX_W+1)'(EDGE_VERTICES - 1);

  front_state_t     state;
  front_state_t     state_next;
  logic [AW-1:0]    count;
  logic             fix_en;
  logic [2:0]       lvl_diff;
  logic             accept;
  logic             at_last;

  logic [2:0]       d;
  logic [IDX_W:0]   idx;
  logic [IDX_W:0]   step;
  logic [IDX_W:0]   r;
  logic [IDX_W:0]   lo;
  logic [IDX_W:0]   hi_raw;
  logic [IDX_W:0]   hi;

  assign accept  = in_valid && !in_stall;
  assign at_last = (count == AW'(EDGE_VERTICES - 1));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fix_en   <= 1'b0;
      lvl_diff <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FIX_ENABLE: fix_en   <= cfg_data[0];
        CFG_LEVEL_DIFF: lvl_diff <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_LOAD:  if (accept && at_last) state_next = F_ISSUE;
      F_ISSUE: if (push && at_last) state_next = F_WAIT;
      F_WAIT:  if (drained) state_next = F_LOAD;
      default: state_next = F_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_LOAD;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept || push) count <= at_last ? '0 : count + 1'b1;
    end
  end

  // Interpolation span of the vertex being issued
  always_comb begin
    d      = (lvl_diff > 3'(D_MAX)) ? 3'(D_MAX) : lvl_diff;
    idx    = (IDX_W+1)'(count);
    step   = (IDX_W+1)'(1) << d;
    r      = idx & (step - 1'b1);
    lo     = idx - r;
    hi_raw = lo + step;
    hi     = (hi_raw > LAST_IDX) ? LAST_IDX : hi_raw;
  end

  // Outputs
  always_comb begin
    in_stall     = (state != F_LOAD);
    wr.en        = accept;
    wr.addr      = IDX_W'(count);
    wr.data      = in_data;
    push         = (state == F_ISSUE) && !fifo_full;
    push_data.last  = at_last;
    push_data.shift = d;
    if (fix_en && !at_last) begin
      push_data.lo   = lo[IDX_W-1:0];
      push_data.hi   = hi[IDX_W-1:0];
      push_data.r    = r[IDX_W-1:0];
      push_data.norm = 1'b1;
    end else begin
      push_data.lo   = idx[IDX_W-1:0];
      push_data.hi   = idx[IDX_W-1:0];
      push_data.r    = '0;
      push_data.norm = 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tes_back.sv =====
`default_nettype none
module tes_back
  import tes_pkg::*;
#(
  parameter int EDGE_VERTICES = EDGE_VERTICES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire store_wr_t wr,
  output logic           pop,
  input  wire task_t     pop_data,
  input  wire logic      fifo_empty,
  output logic           idle,
  output logic           out_valid,
  input  wire logic      out_stall,
  output vtx_out_t       out_data
);
  localparam int AW = $clog2(EDGE_VERTICES);

  vtx_in_t              mem [EDGE_VERTICES];
  vtx_in_t              rd_data;
  logic [IDX_W-1:0]     rd_addr;

  back_state_t          state;
  back_state_t          state_next;
  task_t                task_q;
  vtx_in_t              lo_q;
  logic signed [23:0]   h_res;
  logic signed [15:0]   nv  [3];
  logic signed [15:0]   res [3];
  logic [SQ_W-1:0]      sq  [3];
  logic [LEN_W-1:0]     len;
  logic [1:0]           k;
  logic [CNT_W-1:0]     cnt;
  logic [LEN_W-1:0]     rem;
  logic [NUM_W-1:0]     num;
  logic [Q_W-1:0]       quot;
  logic [Q_W-1:0]       a;
  logic [Q_W-1:0]       root;
  logic [Q_W-1:0]       bitv;

  // Combinational datapath values
  logic signed [15:0]          lo_n [3];
  logic signed [15:0]          hi_n [3];
  logic signed [IDX_W:0]       r_s;
  logic signed [24:0]          hd;
  logic signed [25+IDX_W:0]    hp;
  logic signed [25+IDX_W:0]    hs;
  logic signed [23:0]          h_new;
  logic signed [16:0]          nd   [3];
  logic signed [17+IDX_W:0]    np   [3];
  logic signed [17+IDX_W:0]    ns   [3];
  logic signed [15:0]          n_new [3];
  logic signed [16:0]          ce;
  logic [16:0]                 mag;
  logic [SQ_W-1:0]             sq_new;
  logic [LEN_W:0]              rem_sh;
  logic [LEN_W-1:0]            rem_new;
  logic                        qbit;
  logic [Q_W:0]                trial;
  logic [Q_W-1:0]              a_new;
  logic [Q_W-1:0]              root_new;
  logic signed [15:0]          unit_c;
  logic                        out_free;
  logic                        div_end;
  logic                        sqrt_end;

  assign idle     = (state == B_IDLE);
  assign pop      = (state == B_IDLE) && !fifo_empty;
  assign out_free = !out_valid || !out_stall;
  assign div_end  = (cnt == CNT_W'(DIV_STEPS - 1));
  assign sqrt_end = (cnt == CNT_W'(SQRT_STEPS - 1));

  // Vertex store: one write port from the front, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr[AW-1:0]] <= wr.data;
    rd_data <= mem[rd_addr[AW-1:0]];
  end

  always_comb begin
    rd_addr = (state == B_RD_HI) ? task_q.hi : task_q.lo;
  end

  // Interpolation between the span ends, floor shift by the step exponent
  always_comb begin
    lo_n[0] = lo_q.normal_x;
    lo_n[1] = lo_q.normal_y;
    lo_n[2] = lo_q.normal_z;
    hi_n[0] = rd_data.normal_x;
    hi_n[1] = rd_data.normal_y;
    hi_n[2] = rd_data.normal_z;
    r_s     = {1'b0, task_q.r};
    hd      = 25'(rd_data.vertex_height) - 25'(lo_q.vertex_height);
    hp      = hd * r_s;
    hs      = hp >>> task_q.shift;
    h_new   = lo_q.vertex_height + 24'(hs);
    for (int j = 0; j < 3; j++) begin
      nd[j]    = 17'(hi_n[j]) - 17'(lo_n[j]);
      np[j]    = nd[j] * r_s;
      ns[j]    = np[j] >>> task_q.shift;
      n_new[j] = lo_n[j] + 16'(ns[j]);
    end
  end

  // Square of one component, long-division step, square-root step
  always_comb begin
    ce      = 17'(nv[k]);
    mag     = ce[16] ? 17'(-ce) : 17'(ce);
    sq_new  = SQ_W'(mag * mag);
    rem_sh  = {rem, num[NUM_W-1]};
    qbit    = (rem_sh >= {1'b0, len});
    rem_new = qbit ? LEN_W'(rem_sh - {1'b0, len}) : rem_sh[LEN_W-1:0];
    trial   = {1'b0, root} + {1'b0, bitv};
    if ({1'b0, a} >= trial) begin
      a_new    = Q_W'({1'b0, a} - trial);
      root_new = (root >> 1) + bitv;
    end else begin
      a_new    = a;
      root_new = root >> 1;
    end
    unit_c = nv[k][15] ? -(16'(root_new)) : 16'(root_new);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (!fifo_empty) state_next = B_RD_LO;
      B_RD_LO:  state_next = B_RD_HI;
      B_RD_HI:  state_next = B_INTERP;
      B_INTERP: state_next = task_q.norm ? B_SQ : B_DONE;
      B_SQ:     if (k == 2'd2) state_next = B_DSTART;
      B_DSTART: begin
        if (len != '0)      state_next = B_DIV;
        else if (k == 2'd2) state_next = B_DONE;
      end
      B_DIV:    if (div_end) state_next = B_SQI;
      B_SQI:    state_next = B_SQRT;
      B_SQRT:   if (sqrt_end) state_next = (k == 2'd2) ? B_DONE : B_DSTART;
      B_DONE:   if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (pop) task_q <= pop_data;
      end
      B_RD_LO: ;
      B_RD_HI: lo_q <= rd_data;
      B_INTERP: begin
        h_res <= h_new;
        for (int j = 0; j < 3; j++) begin
          nv[j]  <= n_new[j];
          res[j] <= n_new[j];
        end
        len <= '0;
        k   <= '0;
      end
      B_SQ: begin
        sq[k] <= sq_new;
        len   <= len + LEN_W'(sq_new);
        k     <= (k == 2'd2) ? 2'd0 : k + 1'b1;
      end
      B_DSTART: begin
        if (len == '0) begin
          res[k] <= '0;
          k      <= k + 1'b1;
        end else begin
          num  <= {sq[k], UNIT_SHIFT'(0)};
          rem  <= '0;
          quot <= '0;
          cnt  <= '0;
        end
      end
      B_DIV: begin
        rem  <= rem_new;
        num  <= num << 1;
        quot <= {quot[Q_W-2:0], qbit};
        cnt  <= cnt + 1'b1;
      end
      B_SQI: begin
        a    <= quot;
        root <= '0;
        bitv <= Q_W'(1) << UNIT_SHIFT;
        cnt  <= '0;
      end
      B_SQRT: begin
        a    <= a_new;
        root <= root_new;
        bitv <= bitv >> 2;
        cnt  <= cnt + 1'b1;
        if (sqrt_end) begin
          res[k] <= unit_c;
          k      <= k + 1'b1;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_data.fixed_height <= h_res;
          out_data.fixed_nx     <= res[0];
          out_data.fixed_ny     <= res[1];
          out_data.fixed_nz     <= res[2];
          out_data.last_vertex  <= task_q.last;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/terrain_edge_stitch.sv =====
`default_nettype none
// Channel   Direction  Handshake           Beat
// in        in         in_valid/in_stall   one edge vertex (vtx_in_t)
// out       out        out_valid/out_stall one stitched vertex (vtx_out_t)
// cfg       in         cfg_valid/cfg_ready register index and write data
//
// Loading accepts one vertex per cycle; the last vertex of an edge starts the emit pass,
// during which input is stalled until the back end has finished the last vertex.
// Each emitted vertex is either passed through or renormalised; a zero normal skips the
// divider and square root. When renormalising, the bit-serial divider (59 steps) and the
// square-root unit (15 steps) are run once per normal component.
// Reset is synchronous; the vertex store needs no clearing pass.
module terrain_edge_stitch
  import tes_pkg::*;
#(
  parameter int EDGE_VERTICES = EDGE_VERTICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire vtx_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output vtx_out_t               out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);
  store_wr_t wr;
  logic      push;
  task_t     push_data;
  logic      fifo_full;
  logic      pop;
  task_t     pop_data;
  logic      fifo_empty;
  logic      back_idle;
  logic      drained;

  assign cfg_ready = 1'b1;
  assign drained   = fifo_empty && back_idle;

  tes_front #(.EDGE_VERTICES(EDGE_VERTICES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full),
    .drained   (drained)
  );

  tes_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  tes_back #(.EDGE_VERTICES(EDGE_VERTICES)) u_back (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .pop        (pop),
    .pop_data   (pop_data),
    .fifo_empty (fifo_empty),
    .idle       (back_idle),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );
endmodule
`default_nettype wire
